FILE: rtl/core/spmq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spmq_pkg
// Shared types, codes and widths of the strict-priority multi-queue.
// ----------------------------------------------------------------------------
package spmq_pkg;

    // Default sizes, handed to the top-level parameters
    localparam int LEVELS_DEF      = 8;
    localparam int LEVEL_DEPTH_DEF = 16;
    localparam int TASK_WIDTH_DEF  = 16;

    // Fixed field widths
    localparam int PRI_W     = 3;
    localparam int LIU_W     = 4;
    localparam int LCNT_W    = 5;
    localparam int TOTAL_W   = 8;
    localparam int STATUS_W  = 2;

    // Configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_LEVELS_IN_USE = 1'b0;
    localparam logic [LIU_W-1:0] LIU_RESET = 4'd8;

    // Command queue between front and back
    localparam int QDEPTH = 2;

    // Action codes
    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_PRI = 2'd3;

    // Classified command
    typedef struct packed {
        logic             deq;
        logic [PRI_W-1:0] pri;
        logic             bad_pri;
    } cmd_t;

endpackage
`default_nettype wire

FILE: rtl/core/spmq_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spmq_front
// Accepts commands, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module spmq_front #(
    parameter int TASK_WIDTH = spmq_pkg::TASK_WIDTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         accept,
    input  wire logic                         action,
    input  wire logic [spmq_pkg::PRI_W-1:0]   priority_req,
    input  wire logic [TASK_WIDTH-1:0]        task_id,
    input  wire logic [spmq_pkg::LIU_W-1:0]   n_eff,
    input  wire logic                         q_pop,
    output logic                              q_full,
    output logic                              q_valid,
    output spmq_pkg::cmd_t                    q_cmd,
    output logic [TASK_WIDTH-1:0]             q_task
);

    localparam int QAW = $clog2(spmq_pkg::QDEPTH);
    localparam int QCW = $clog2(spmq_pkg::QDEPTH + 1);

    spmq_pkg::cmd_t          cmd_mem [spmq_pkg::QDEPTH];
    logic [TASK_WIDTH-1:0]   task_mem [spmq_pkg::QDEPTH];
    logic [QAW-1:0]          wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]          count_reg, count_next;
    spmq_pkg::cmd_t          new_cmd;

    // Classify: a level at or beyond the count in use is a bad priority
    always_comb
    begin
        new_cmd.deq     = (action == spmq_pkg::ACT_DEQ);
        new_cmd.pri     = priority_req;
        new_cmd.bad_pri = ({1'b0, priority_req} >= n_eff);
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (accept)
        begin
            wr_ptr_next = (wr_ptr_reg == QAW'(spmq_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + QAW'(1);
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QAW'(spmq_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + QAW'(1);
        end
        if (accept && !q_pop)
        begin
            count_next = count_reg + QCW'(1);
        end
        else if (!accept && q_pop)
        begin
            count_next = count_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_mem[wr_ptr_reg]  <= new_cmd;
            task_mem[wr_ptr_reg] <= task_id;
        end
    end

    assign q_full  = (count_reg == QCW'(spmq_pkg::QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_cmd   = cmd_mem[rd_ptr_reg];
    assign q_task  = task_mem[rd_ptr_reg];

endmodule
`default_nettype wire

FILE: rtl/core/spmq_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spmq_back
// Sequencer over the level table and task memory; executes queued commands.
// ----------------------------------------------------------------------------
module spmq_back #(
    parameter int LEVELS      = spmq_pkg::LEVELS_DEF,
    parameter int LEVEL_DEPTH = spmq_pkg::LEVEL_DEPTH_DEF,
    parameter int TASK_WIDTH  = spmq_pkg::TASK_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr,
    input  wire logic [spmq_pkg::LIU_W-1:0]    n_eff,
    input  wire logic                          q_valid,
    input  wire spmq_pkg::cmd_t                q_cmd,
    input  wire logic [TASK_WIDTH-1:0]         q_task,
    output logic                               q_pop,
    output logic                               sweeping,
    output logic                               done,
    output logic [TASK_WIDTH-1:0]              out_task,
    output logic                               out_valid,
    output logic [TASK_WIDTH-1:0]              head_task,
    output logic                               head_valid,
    output logic [spmq_pkg::LCNT_W-1:0]        level_count,
    output logic [spmq_pkg::TOTAL_W-1:0]       total_count,
    output logic                               all_empty,
    output logic [spmq_pkg::STATUS_W-1:0]      status
);

    localparam int LVL_W  = $clog2(LEVELS);
    localparam int PTR_W  = $clog2(LEVEL_DEPTH);
    localparam int FILL_W = $clog2(LEVEL_DEPTH + 1);
    localparam int TOT_W  = $clog2(LEVELS * LEVEL_DEPTH + 1);
    localparam int SA_W   = LVL_W + PTR_W;
    localparam int SDEPTH = LEVELS * (1 << PTR_W);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEL    = 3'd1;
    localparam logic [2:0] S_UPD    = 3'd2;
    localparam logic [2:0] S_HEAD   = 3'd3;
    localparam logic [2:0] S_HPTR   = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;
    localparam logic [2:0] S_SUM    = 3'd6;
    localparam logic [2:0] S_SUMEND = 3'd7;

    // Level table: head, tail and fill per level, valid bits for reset
    logic [PTR_W-1:0]  head_mem [LEVELS];
    logic [PTR_W-1:0]  tail_mem [LEVELS];
    logic [FILL_W-1:0] fill_mem [LEVELS];
    logic [LEVELS-1:0] lv_valid_reg;
    logic [LEVELS-1:0] nz_reg;
    logic [PTR_W-1:0]  rd_head_reg, rd_tail_reg;
    logic [FILL_W-1:0] rd_fill_reg;

    // Task store, one ring per level
    logic [TASK_WIDTH-1:0] task_mem [SDEPTH];
    logic [TASK_WIDTH-1:0] tsk_rd_reg;

    logic [2:0]                      state_reg, state_next;
    logic                            deq_reg, bad_pri_reg;
    logic [spmq_pkg::PRI_W-1:0]      pri_reg;
    logic [TASK_WIDTH-1:0]           task_reg;
    logic [LVL_W-1:0]                tgt_reg, hlvl_reg;
    logic                            found_reg, hvalid_reg, taken_reg;
    logic [spmq_pkg::STATUS_W-1:0]   status_reg;
    logic [TASK_WIDTH-1:0]           taken_task_reg;
    logic [TOT_W-1:0]                total_reg;
    logic                            sweep_pend_reg, sweep_chk_reg;
    logic [LVL_W-1:0]                sweep_idx_reg, sweep_lvl_reg;
    logic                            done_reg;
    logic [TASK_WIDTH-1:0]           out_task_reg, head_task_reg;
    logic                            out_valid_reg, head_valid_reg;
    logic [spmq_pkg::LCNT_W-1:0]     level_count_reg;
    logic [spmq_pkg::TOTAL_W-1:0]    total_count_reg;
    logic [spmq_pkg::STATUS_W-1:0]   status_out_reg;

    logic [LEVELS-1:0] in_use;
    logic [LEVELS-1:0] avail;
    logic [LVL_W-1:0]  first_lvl;
    logic [LVL_W-1:0]  pri_lvl;
    logic [LVL_W-1:0]  tbl_rd_addr;
    logic [SA_W-1:0]   tsk_rd_addr;
    logic              tbl_we;
    logic [PTR_W-1:0]  wr_head, wr_tail;
    logic [FILL_W-1:0] wr_fill;
    logic              tsk_we;
    logic              enq_ok, deq_ok;

    function automatic logic [LVL_W-1:0] first_set(input logic [LEVELS-1:0] v);
        logic [LVL_W-1:0] r;
        r = '0;
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = LVL_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    for (genvar g = 0; g < LEVELS; g++)
    begin : g_use
        assign in_use[g] = (32'(n_eff) > g);
    end

    assign avail     = nz_reg & in_use;
    assign first_lvl = first_set(avail);
    assign pri_lvl   = LVL_W'(pri_reg);

    // Enqueue goes ahead unless the priority is bad or the level is full
    assign enq_ok = !deq_reg && !bad_pri_reg && (rd_fill_reg != FILL_W'(LEVEL_DEPTH));
    assign deq_ok = deq_reg && found_reg;

    always_comb
    begin
        state_next  = state_reg;
        q_pop       = 1'b0;
        tbl_rd_addr = '0;
        tsk_rd_addr = '0;
        tbl_we      = 1'b0;
        tsk_we      = 1'b0;
        wr_head     = rd_head_reg;
        wr_tail     = rd_tail_reg;
        wr_fill     = rd_fill_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (sweep_pend_reg)
                begin
                    state_next = S_SUM;
                end
                else if (q_valid)
                begin
                    q_pop      = 1'b1;
                    state_next = S_SEL;
                end
            end
            S_SEL:
            begin
                tbl_rd_addr = deq_reg ? first_lvl : pri_lvl;
                state_next  = S_UPD;
            end
            S_UPD:
            begin
                tsk_rd_addr = {tgt_reg, rd_head_reg};
                if (state_reg == S_UPD && enq_ok)
                begin
                    tbl_we  = 1'b1;
                    tsk_we  = 1'b1;
                    wr_tail = ring_next(rd_tail_reg);
                    wr_fill = rd_fill_reg + FILL_W'(1);
                end
                else if (deq_ok)
                begin
                    tbl_we  = 1'b1;
                    wr_head = ring_next(rd_head_reg);
                    wr_fill = rd_fill_reg - FILL_W'(1);
                end
                state_next = S_HEAD;
            end
            S_HEAD:
            begin
                tbl_rd_addr = first_lvl;
                state_next  = S_HPTR;
            end
            S_HPTR:
            begin
                tsk_rd_addr = {hlvl_reg, rd_head_reg};
                tbl_rd_addr = pri_lvl;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            S_SUM:
            begin
                tbl_rd_addr = sweep_idx_reg;
                if (sweep_idx_reg == LVL_W'(LEVELS - 1))
                begin
                    state_next = S_SUMEND;
                end
            end
            S_SUMEND:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Level table and task store
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            head_mem[tgt_reg] <= wr_head;
            tail_mem[tgt_reg] <= wr_tail;
            fill_mem[tgt_reg] <= wr_fill;
        end
        rd_head_reg <= lv_valid_reg[tbl_rd_addr] ? head_mem[tbl_rd_addr] : '0;
        rd_tail_reg <= lv_valid_reg[tbl_rd_addr] ? tail_mem[tbl_rd_addr] : '0;
        rd_fill_reg <= lv_valid_reg[tbl_rd_addr] ? fill_mem[tbl_rd_addr] : '0;
    end

    always_ff @(posedge clk)
    begin
        if (tsk_we)
        begin
            task_mem[{tgt_reg, rd_tail_reg}] <= task_reg;
        end
        tsk_rd_reg <= task_mem[tsk_rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            lv_valid_reg   <= '0;
            nz_reg         <= '0;
            total_reg      <= '0;
            sweep_pend_reg <= 1'b0;
            sweep_chk_reg  <= 1'b0;
            sweep_idx_reg  <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_OUT);
            if (cfg_wr)
            begin
                sweep_pend_reg <= 1'b1;
            end
            if (tbl_we)
            begin
                lv_valid_reg[tgt_reg] <= 1'b1;
                nz_reg[tgt_reg]       <= (wr_fill != '0);
            end
            if (state_reg == S_UPD && enq_ok)
            begin
                total_reg <= total_reg + TOT_W'(1);
            end
            else if (state_reg == S_UPD && deq_ok)
            begin
                total_reg <= total_reg - TOT_W'(1);
            end
            // Recount the total fill of the levels in use after a write to the level count
            if (state_reg == S_IDLE && sweep_pend_reg)
            begin
                sweep_pend_reg <= 1'b0;
                sweep_chk_reg  <= 1'b0;
                sweep_idx_reg  <= '0;
                total_reg      <= '0;
            end
            if (state_reg == S_SUM)
            begin
                sweep_chk_reg <= 1'b1;
                if (sweep_idx_reg != LVL_W'(LEVELS - 1))
                begin
                    sweep_idx_reg <= sweep_idx_reg + LVL_W'(1);
                end
            end
            if ((state_reg == S_SUM || state_reg == S_SUMEND) && sweep_chk_reg &&
                in_use[sweep_lvl_reg])
            begin
                total_reg <= total_reg + TOT_W'(rd_fill_reg);
            end
        end
    end

    // Item context and result payload
    always_ff @(posedge clk)
    begin
        sweep_lvl_reg <= sweep_idx_reg;
        if (q_pop)
        begin
            deq_reg     <= q_cmd.deq;
            pri_reg     <= q_cmd.pri;
            bad_pri_reg <= q_cmd.bad_pri;
            task_reg    <= q_task;
        end
        if (state_reg == S_SEL)
        begin
            tgt_reg   <= deq_reg ? first_lvl : pri_lvl;
            found_reg <= (avail != '0);
            if (deq_reg)
            begin
                status_reg <= (avail != '0) ? spmq_pkg::ST_OK : spmq_pkg::ST_EMPTY;
            end
            else
            begin
                status_reg <= bad_pri_reg ? spmq_pkg::ST_BAD_PRI : spmq_pkg::ST_OK;
            end
        end
        if (state_reg == S_UPD)
        begin
            taken_reg <= deq_ok;
            if (!deq_reg && !bad_pri_reg && !enq_ok)
            begin
                status_reg <= spmq_pkg::ST_FULL;
            end
        end
        if (state_reg == S_HEAD)
        begin
            taken_task_reg <= tsk_rd_reg;
            hlvl_reg       <= first_lvl;
            hvalid_reg     <= (avail != '0);
        end
        if (state_reg == S_OUT)
        begin
            out_task_reg    <= taken_reg ? taken_task_reg : '0;
            out_valid_reg   <= taken_reg;
            head_task_reg   <= hvalid_reg ? tsk_rd_reg : '0;
            head_valid_reg  <= hvalid_reg;
            level_count_reg <= bad_pri_reg ? '0 : spmq_pkg::LCNT_W'(rd_fill_reg);
            total_count_reg <= spmq_pkg::TOTAL_W'(total_reg);
            status_out_reg  <= status_reg;
        end
    end

    assign sweeping    = sweep_pend_reg || (state_reg == S_SUM) || (state_reg == S_SUMEND);
    assign done        = done_reg;
    assign out_task    = out_task_reg;
    assign out_valid   = out_valid_reg;
    assign head_task   = head_task_reg;
    assign head_valid  = head_valid_reg;
    assign level_count = level_count_reg;
    assign total_count = total_count_reg;
    assign all_empty   = !head_valid_reg;
    assign status      = status_out_reg;

endmodule
`default_nettype wire

FILE: rtl/core/strict_priority_multi_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// strict_priority_multi_queue
// Strict-priority task queue: one FIFO of task identifiers per level.
// ----------------------------------------------------------------------------
// A command is taken at a rising edge with start high and busy low. Each
// command yields exactly one result, shown for one cycle with done high; the
// receiver cannot stall, so capture the result on that cycle. For each
// command the back end walks the level table (one read port)
// and the task memory (one read and one write port) in a fixed order to
// select the level, update its ring, find the new head level, read the head
// task and read the reported level's fill. A two-entry command queue takes
// further commands while the back end works; busy rises when it is full.
// A write to levels_in_use makes the block recount the total fill of the
// levels in use, holding busy until the recount is done.
// Level 0 has the highest priority. Tasks at levels beyond the count in use
// are kept and come back into view when the count grows again.
// ----------------------------------------------------------------------------
module strict_priority_multi_queue #(
    parameter int LEVELS      = spmq_pkg::LEVELS_DEF,
    parameter int LEVEL_DEPTH = spmq_pkg::LEVEL_DEPTH_DEF,
    parameter int TASK_WIDTH  = spmq_pkg::TASK_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // Configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [spmq_pkg::APB_AW-1:0]    paddr,
    input  wire logic [spmq_pkg::APB_DW-1:0]    pwdata,
    output logic [spmq_pkg::APB_DW-1:0]         prdata,
    output logic                                pready,
    // Command channel
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           action,
    input  wire logic [spmq_pkg::PRI_W-1:0]     priority_req,
    input  wire logic [TASK_WIDTH-1:0]          task_id,
    // Result channel
    output logic                                done,
    output logic [TASK_WIDTH-1:0]               out_task,
    output logic                                out_valid,
    output logic [TASK_WIDTH-1:0]               head_task,
    output logic                                head_valid,
    output logic [spmq_pkg::LCNT_W-1:0]         level_count,
    output logic [spmq_pkg::TOTAL_W-1:0]        total_count,
    output logic                                all_empty,
    output logic [spmq_pkg::STATUS_W-1:0]       status
);

    // Largest level count the register can hold, capped by the build size
    localparam int CAP = (LEVELS > 15) ? 15 : LEVELS;

    logic [spmq_pkg::LIU_W-1:0] levels_in_use_reg, levels_in_use_next;
    logic [spmq_pkg::LIU_W-1:0] n_eff;
    logic                       cfg_wr;
    logic                       accept;
    logic                       q_full, q_valid, q_pop, sweeping;
    spmq_pkg::cmd_t             q_cmd;
    logic [TASK_WIDTH-1:0]      q_task;

    // Register write completes on the access phase of the transfer
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[2] == spmq_pkg::REG_LEVELS_IN_USE);

    always_comb
    begin
        levels_in_use_next = levels_in_use_reg;
        if (cfg_wr)
        begin
            levels_in_use_next = pwdata[spmq_pkg::LIU_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_in_use_reg <= spmq_pkg::LIU_RESET;
        end
        else
        begin
            levels_in_use_reg <= levels_in_use_next;
        end
    end

    always_comb
    begin
        if (paddr[2] == spmq_pkg::REG_LEVELS_IN_USE)
        begin
            prdata = {{(spmq_pkg::APB_DW - spmq_pkg::LIU_W){1'b0}}, levels_in_use_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    // Treat a count of zero as one level, clamp a large count to the build
    always_comb
    begin
        if (levels_in_use_reg == '0)
        begin
            n_eff = spmq_pkg::LIU_W'(1);
        end
        else if (levels_in_use_reg > spmq_pkg::LIU_W'(CAP))
        begin
            n_eff = spmq_pkg::LIU_W'(CAP);
        end
        else
        begin
            n_eff = levels_in_use_reg;
        end
    end

    // Hold off new commands while the queue is full or the total is recounted
    assign busy   = q_full || sweeping;
    assign accept = start && !busy;

    spmq_front #(
        .TASK_WIDTH   (TASK_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .action       (action),
        .priority_req (priority_req),
        .task_id      (task_id),
        .n_eff        (n_eff),
        .q_pop        (q_pop),
        .q_full       (q_full),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_task       (q_task)
    );

    spmq_back #(
        .LEVELS       (LEVELS),
        .LEVEL_DEPTH  (LEVEL_DEPTH),
        .TASK_WIDTH   (TASK_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr       (cfg_wr),
        .n_eff        (n_eff),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_task       (q_task),
        .q_pop        (q_pop),
        .sweeping     (sweeping),
        .done         (done),
        .out_task     (out_task),
        .out_valid    (out_valid),
        .head_task    (head_task),
        .head_valid   (head_valid),
        .level_count  (level_count),
        .total_count  (total_count),
        .all_empty    (all_empty),
        .status       (status)
    );

endmodule
`default_nettype wire
